FILE: sv/smi_pkg.sv
// shared constants and permutation tables for the small matrix inverse
`default_nettype none
package smi_pkg;

	localparam int SMI_ELEM_WIDTH = 32;
	localparam int SMI_FRAC_BITS  = 16;
	localparam int SMI_SIZE_W     = 3;

	localparam logic [SMI_SIZE_W-1:0] SMI_SIZE_3X3   = 3'd3;
	localparam logic [SMI_SIZE_W-1:0] SMI_SIZE_RESET = 3'd4;

	// column pick of factor p in permutation t of a 2x2 or 3x3 minor
	function automatic logic [1:0] smi_perm_col(input logic k2, input logic [2:0] t,
			input logic [1:0] p);
		logic [1:0] col;
		col = 2'd0;
		if (k2) begin
			col = (t[0] ^ p[0]) ? 2'd1 : 2'd0;
		end else begin
			unique case (t)
				3'd0: col = p;
				3'd1: col = (p == 2'd0) ? 2'd0 : ((p == 2'd1) ? 2'd2 : 2'd1);
				3'd2: col = (p == 2'd0) ? 2'd1 : ((p == 2'd1) ? 2'd0 : 2'd2);
				3'd3: col = (p == 2'd0) ? 2'd1 : ((p == 2'd1) ? 2'd2 : 2'd0);
				3'd4: col = (p == 2'd0) ? 2'd2 : ((p == 2'd1) ? 2'd0 : 2'd1);
				3'd5: col = (p == 2'd0) ? 2'd2 : ((p == 2'd1) ? 2'd1 : 2'd0);
				default: col = 2'd0;
			endcase
		end
		return col;
	endfunction

	// odd permutations subtract
	function automatic logic smi_perm_neg(input logic k2, input logic [2:0] t);
		logic neg;
		if (k2) begin
			neg = t[0];
		end else begin
			neg = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
		end
		return neg;
	endfunction

endpackage
`default_nettype wire

FILE: sv/smi_ram.sv
// generic single-clock ram, one write port, one registered read port
`default_nettype none
module smi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/small_matrix_inverse_top.sv
// small matrix inverse: 3x3 or 4x4 fixed-point inverse by adjugate and determinant
//
// Elements enter on the element channel (element_valid / element_stall), one signed
// fixed-point word per item, row-major. The size register (cfg_write_en, cfg_write_data)
// picks 3x3 when it holds 3, else 4x4; reset sets 4. Write it only while idle.
// Loading takes one word per cycle. After the last word the block stalls its input,
// builds every cofactor in a cofactor ram from the element ram (bit-serial
// multiplies, each term a product of n-1 elements; 6 terms for 4x4, 2 for 3x3),
// forms the determinant from row 0, then per entry runs a restoring divider.
// Results leave row-major on the result channel with row, column, singular,
// overflow and last. A zero determinant gives all-zero words with singular set.
// When the receiver stalls, the output register holds and the sequencer waits.
// Reset clears the load count, the control and the output valid; ram contents stay.
`default_nettype none
module small_matrix_inverse_top #(
	parameter int ELEM_WIDTH = smi_pkg::SMI_ELEM_WIDTH,
	parameter int FRAC_BITS  = smi_pkg::SMI_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write_en,
	input  wire logic [smi_pkg::SMI_SIZE_W-1:0]      cfg_write_data,
	input  wire logic                                element_valid,
	output logic                                     element_stall,
	input  wire logic signed [ELEM_WIDTH-1:0]        element_value,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic signed [ELEM_WIDTH-1:0]             result_value,
	output logic [1:0]                               result_row,
	output logic [1:0]                               result_col,
	output logic                                     singular,
	output logic                                     overflow,
	output logic                                     last
);
	import smi_pkg::*;

	localparam int WW = 4 * ELEM_WIDTH + 6;
	localparam int QB = ELEM_WIDTH + 1;
	localparam int XW = WW + 2 * FRAC_BITS + QB;
	localparam int BW = $clog2(QB + 1);

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_START  = 16'h0002,
		S_RD     = 16'h0004,
		S_LD     = 16'h0008,
		S_MUL    = 16'h0010,
		S_ACC    = 16'h0020,
		S_COF    = 16'h0040,
		S_DACC   = 16'h0080,
		S_NEXTC  = 16'h0100,
		S_PSTART = 16'h0200,
		S_ORD    = 16'h0400,
		S_OLD    = 16'h0800,
		S_OCHK   = 16'h1000,
		S_DIV    = 16'h2000,
		S_SAT    = 16'h4000,
		S_EMIT   = 16'h8000
	} state_t;

	state_t state_q;

	logic [SMI_SIZE_W-1:0] size_q;
	logic [4:0]            cnt_q;
	logic [1:0]            r_q, c_q, p_q;
	logic [2:0]            t_q;
	logic [BW-1:0]         b_q;
	logic                  detm_q;

	logic signed [WW-1:0]  prod_q, mc_q, res_q, cacc_q, cof_q, det_q;
	logic [ELEM_WIDTH-1:0] mp_q;
	logic [WW-1:0]         dmag_q;
	logic                  dneg_q, sing_q, neg_q, ovf_q;
	logic [XW-1:0]         rem_q, dsh_q;
	logic [QB-1:0]         qt_q;
	logic [ELEM_WIDTH-1:0] val_q;

	logic                  rv_q, rsing_q, rovf_q, rlast_q;
	logic [ELEM_WIDTH-1:0] rval_q;
	logic [1:0]            rrow_q, rcol_q;

	logic                  n3;
	logic [4:0]            nsq;
	logic [1:0]            kmax, nlast;
	logic [2:0]            tlast;
	logic                  accept;
	logic [4:0]            cnt_next;

	logic [1:0]            rs, pc, cs;
	logic [3:0]            eaddr, mraddr;
	logic [ELEM_WIDTH-1:0] mrdata;
	logic [WW-1:0]         crdata;
	logic signed [WW-1:0]  cof_val, addend, res_new, elem_sx, cabs;
	logic [XW-1:0]         dx;
	logic                  ge;
	logic [QB-1:0]         lim, qs;
	logic                  big;
	logic                  out_free;

	assign n3    = (size_q == SMI_SIZE_3X3);
	assign nsq   = n3 ? 5'd9 : 5'd16;
	assign kmax  = n3 ? 2'd1 : 2'd2;
	assign nlast = n3 ? 2'd2 : 2'd3;
	assign tlast = n3 ? 3'd1 : 3'd5;

	assign element_stall = (state_q != S_IDLE);
	assign accept        = element_valid && !element_stall;
	assign cnt_next      = cnt_q + 5'd1;

	// rows and columns of the minor skip the cofactor's own row and column
	always_comb begin
		rs = p_q + {1'b0, (p_q >= r_q)};
		pc = smi_perm_col(n3, t_q, p_q);
		cs = pc + {1'b0, (pc >= c_q)};
		if (n3) begin
			eaddr = {rs, 1'b0} + {2'b00, rs} + {2'b00, cs};
		end else begin
			eaddr = {rs, cs};
		end
		mraddr = detm_q ? {2'b00, c_q} : eaddr;
	end

	smi_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(16)) u_elem_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(cnt_q[3:0]),
		.wdata(element_value),
		.raddr(mraddr),
		.rdata(mrdata)
	);

	assign cof_val = (r_q[0] ^ c_q[0]) ? -cacc_q : cacc_q;

	smi_ram #(.WIDTH(WW), .DEPTH(16)) u_cof_ram (
		.clk  (clk),
		.we   (state_q == S_COF),
		.waddr({r_q, c_q}),
		.wdata(cof_val),
		.raddr({c_q, r_q}),
		.rdata(crdata)
	);

	always_comb begin
		elem_sx = {{(WW-ELEM_WIDTH){mrdata[ELEM_WIDTH-1]}}, mrdata};
		// top multiplier bit carries negative weight
		addend  = (b_q == BW'(ELEM_WIDTH - 1)) ? -mc_q : mc_q;
		res_new = mp_q[0] ? res_q + addend : res_q;
		cabs    = crdata[WW-1] ? -$signed(crdata) : $signed(crdata);
		dx      = {{(XW-WW){1'b0}}, dmag_q} << QB;
		ge      = (rem_q >= dsh_q);
		lim     = (QB'(1) << (ELEM_WIDTH - 1)) - QB'(!neg_q);
		big     = ovf_q || (qt_q > lim);
		qs      = big ? lim : qt_q;
	end

	assign out_free = !rv_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SMI_SIZE_RESET;
			cnt_q   <= 5'd0;
			state_q <= S_IDLE;
			rv_q    <= 1'b0;
			r_q     <= 2'd0;
			c_q     <= 2'd0;
			t_q     <= 3'd0;
			p_q     <= 2'd0;
			b_q     <= '0;
			detm_q  <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				size_q <= cfg_write_data;
			end
			if (state_q == S_EMIT && out_free) begin
				rv_q <= 1'b1;
			end else if (!result_stall) begin
				rv_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cnt_next >= nsq) begin
							cnt_q   <= 5'd0;
							state_q <= S_START;
						end else begin
							cnt_q <= cnt_next;
						end
					end
				end
				S_START: begin
					r_q     <= 2'd0;
					c_q     <= 2'd0;
					t_q     <= 3'd0;
					p_q     <= 2'd0;
					detm_q  <= 1'b0;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					b_q <= '0;
					if (!detm_q && p_q == 2'd0) begin
						p_q     <= 2'd1;
						state_q <= S_RD;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (b_q == BW'(ELEM_WIDTH - 1)) begin
						if (detm_q) begin
							state_q <= S_DACC;
						end else if (p_q == kmax) begin
							state_q <= S_ACC;
						end else begin
							p_q     <= p_q + 2'd1;
							state_q <= S_RD;
						end
					end else begin
						b_q <= b_q + BW'(1);
					end
				end
				S_ACC: begin
					if (t_q == tlast) begin
						state_q <= S_COF;
					end else begin
						t_q     <= t_q + 3'd1;
						p_q     <= 2'd0;
						state_q <= S_RD;
					end
				end
				S_COF: begin
					if (r_q == 2'd0) begin
						detm_q  <= 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_NEXTC;
					end
				end
				S_DACC: state_q <= S_NEXTC;
				S_NEXTC: begin
					t_q    <= 3'd0;
					p_q    <= 2'd0;
					detm_q <= 1'b0;
					if (c_q == nlast) begin
						c_q <= 2'd0;
						if (r_q == nlast) begin
							r_q     <= 2'd0;
							state_q <= S_PSTART;
						end else begin
							r_q     <= r_q + 2'd1;
							state_q <= S_RD;
						end
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_RD;
					end
				end
				S_PSTART: state_q <= S_ORD;
				S_ORD:    state_q <= S_OLD;
				S_OLD:    state_q <= sing_q ? S_EMIT : S_OCHK;
				S_OCHK: begin
					if (rem_q >= dx) begin
						state_q <= S_SAT;
					end else begin
						b_q     <= BW'(QB - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (b_q == '0) begin
						state_q <= S_SAT;
					end else begin
						b_q <= b_q - BW'(1);
					end
				end
				S_SAT: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						if (c_q == nlast) begin
							c_q <= 2'd0;
							if (r_q == nlast) begin
								r_q     <= 2'd0;
								state_q <= S_IDLE;
							end else begin
								r_q     <= r_q + 2'd1;
								state_q <= S_ORD;
							end
						end else begin
							c_q     <= c_q + 2'd1;
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_START: begin
				cacc_q <= '0;
				det_q  <= '0;
			end
			S_LD: begin
				res_q <= '0;
				mp_q  <= mrdata;
				if (detm_q) begin
					mc_q <= cof_q;
				end else if (p_q == 2'd0) begin
					prod_q <= elem_sx;
				end else begin
					mc_q <= prod_q;
				end
			end
			S_MUL: begin
				res_q <= res_new;
				mc_q  <= mc_q <<< 1;
				mp_q  <= mp_q >> 1;
				if (b_q == BW'(ELEM_WIDTH - 1)) begin
					prod_q <= res_new;
				end
			end
			S_ACC: begin
				cacc_q <= smi_perm_neg(n3, t_q) ? cacc_q - prod_q : cacc_q + prod_q;
			end
			S_COF:  cof_q  <= cof_val;
			S_DACC: det_q  <= det_q + prod_q;
			S_NEXTC: cacc_q <= '0;
			S_PSTART: begin
				sing_q <= (det_q == '0);
				dneg_q <= det_q[WW-1];
				dmag_q <= det_q[WW-1] ? -det_q : det_q;
			end
			S_OLD: begin
				neg_q <= crdata[WW-1] ^ dneg_q;
				ovf_q <= 1'b0;
				val_q <= '0;
				rem_q <= {{(XW-WW){1'b0}}, cabs} << (2 * FRAC_BITS);
			end
			S_OCHK: begin
				if (rem_q >= dx) begin
					ovf_q <= 1'b1;
				end
				dsh_q <= {{(XW-WW){1'b0}}, dmag_q} << (QB - 1);
				qt_q  <= '0;
			end
			S_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				qt_q  <= {qt_q[QB-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			S_SAT: begin
				ovf_q <= big;
				val_q <= neg_q ? -qs[ELEM_WIDTH-1:0] : qs[ELEM_WIDTH-1:0];
			end
			S_EMIT: begin
				if (out_free) begin
					rval_q  <= val_q;
					rrow_q  <= r_q;
					rcol_q  <= c_q;
					rsing_q <= sing_q;
					rovf_q  <= ovf_q;
					rlast_q <= (r_q == nlast) && (c_q == nlast);
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = rv_q;
	assign result_value = rval_q;
	assign result_row   = rrow_q;
	assign result_col   = rcol_q;
	assign singular     = rsing_q;
	assign overflow     = rovf_q;
	assign last         = rlast_q;

endmodule
`default_nettype wire
